[src/dhcp_tlv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_tlv_pkg
// Types and constants shared by the option-area TLV parser and its checker.
// ----------------------------------------------------------------------------
package dhcp_tlv_pkg;

    localparam int POS_W = 10;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [7:0] OPT_PAD       = 8'd0;
    localparam logic [7:0] OPT_END       = 8'd255;
    localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
    localparam logic [7:0] OPT_SERVER_ID = 8'd54;
    localparam logic [7:0] OPT_REQ_IP    = 8'd50;
    localparam logic [7:0] VIDX_MAX      = 8'd255;

    localparam logic [1:0] SRC_NONE   = 2'd0;
    localparam logic [1:0] SRC_YOUR   = 2'd1;
    localparam logic [1:0] SRC_CLIENT = 2'd2;
    localparam logic [1:0] SRC_REQ    = 2'd3;

    typedef enum logic [3:0] {
        PH_CODE  = 4'b0001,
        PH_LEN   = 4'b0010,
        PH_VALUE = 4'b0100,
        PH_END   = 4'b1000
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic [7:0]       code;
        logic [7:0]       left;
        logic [7:0]       vidx;
        logic [POS_W-1:0] pos;
        logic [7:0]       type_val;
        logic [31:0]      server_val;
        logic [31:0]      req_val;
        logic             req_seen;
        logic [31:0]      your_addr;
        logic [31:0]      client_addr;
    } parse_state_t;

    typedef struct packed {
        logic [7:0]  message_type;
        logic [31:0] server_id;
        logic [31:0] requested_ip;
        logic [31:0] offered_ip;
        logic [1:0]  offered_source;
        logic        end_seen;
    } result_t;

endpackage

[src/dhcp_tlv_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_tlv_in_if
// Request channel carrying one option-area byte and its header fields.
// ----------------------------------------------------------------------------
interface dhcp_tlv_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  opt_byte;
    logic        first_byte;
    logic        last_byte;
    logic [31:0] your_addr;
    logic [31:0] client_addr;

    modport source (
        output valid, opt_byte, first_byte, last_byte, your_addr, client_addr,
        input  ready
    );
    modport sink (
        input  valid, opt_byte, first_byte, last_byte, your_addr, client_addr,
        output ready
    );
endinterface

[src/dhcp_tlv_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_tlv_out_if
// Result channel carrying the parsed summary of one message.
// ----------------------------------------------------------------------------
interface dhcp_tlv_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  message_type;
    logic [31:0] server_id;
    logic [31:0] requested_ip;
    logic [31:0] offered_ip;
    logic [1:0]  offered_source;
    logic        end_seen;

    modport source (
        output valid, message_type, server_id, requested_ip, offered_ip,
               offered_source, end_seen,
        input  ready
    );
    modport sink (
        input  valid, message_type, server_id, requested_ip, offered_ip,
               offered_source, end_seen,
        output ready
    );
endinterface

[src/dhcp_option_tlv_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_option_tlv_parser_top
// DHCP option-area TLV walker: one byte per request, one summary per message.
// ----------------------------------------------------------------------------
// result: res.valid rises when a last-byte request, held in the input register, is processed into the result register
// throughput: one request per cycle; the next parse state is computed combinationally
// from the input register, and a result register separates the result channel;
// a last byte stalls the input only while an earlier result is still unread
// reset: rst_n asynchronous active low, clears parse state and both valid flags
module dhcp_option_tlv_parser_top #(
    parameter int OPTION_AREA_BYTES = 308
) (
    input  logic             clk,
    input  logic             rst_n,
    dhcp_tlv_in_if.sink      opt,
    dhcp_tlv_out_if.source   res
);

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_first_reg;
    logic        s1_last_reg;
    logic [31:0] s1_your_reg;
    logic [31:0] s1_client_reg;

    logic                  out_valid_reg;
    dhcp_tlv_pkg::result_t out_data_reg;
    dhcp_tlv_pkg::result_t summary;

    logic out_free;
    logic process;
    logic take_in;

    assign out_free  = !out_valid_reg || res.ready;
    // a last byte waits in the input register while the result slot is full
    assign process   = s1_valid_reg && (!s1_last_reg || out_free);
    assign opt.ready = !s1_valid_reg || process;
    assign take_in   = opt.valid && opt.ready;

    dhcp_tlv_core #(
        .OPTION_AREA_BYTES(OPTION_AREA_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (process),
        .opt_byte   (s1_byte_reg),
        .first_byte (s1_first_reg),
        .your_addr  (s1_your_reg),
        .client_addr(s1_client_reg),
        .summary    (summary)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (opt.ready)
            s1_valid_reg <= opt.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_byte_reg   <= opt.opt_byte;
            s1_first_reg  <= opt.first_byte;
            s1_last_reg   <= opt.last_byte;
            s1_your_reg   <= opt.your_addr;
            s1_client_reg <= opt.client_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (process && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (process && s1_last_reg)
            out_data_reg <= summary;
    end

    assign res.valid          = out_valid_reg;
    assign res.message_type   = out_data_reg.message_type;
    assign res.server_id      = out_data_reg.server_id;
    assign res.requested_ip   = out_data_reg.requested_ip;
    assign res.offered_ip     = out_data_reg.offered_ip;
    assign res.offered_source = out_data_reg.offered_source;
    assign res.end_seen       = out_data_reg.end_seen;

endmodule

[src/dhcp_tlv_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_tlv_core
// Parse state and one-byte TLV walk; gives the summary after the current byte.
// ----------------------------------------------------------------------------
module dhcp_tlv_core #(
    parameter int OPTION_AREA_BYTES = 308
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            opt_byte,
    input  logic                  first_byte,
    input  logic [31:0]           your_addr,
    input  logic [31:0]           client_addr,
    output dhcp_tlv_pkg::result_t summary
);

    localparam logic [dhcp_tlv_pkg::POS_W-1:0] AREA_LIMIT =
        dhcp_tlv_pkg::POS_W'(OPTION_AREA_BYTES);

    dhcp_tlv_pkg::parse_state_t st_reg;
    dhcp_tlv_pkg::parse_state_t st_next;
    dhcp_tlv_pkg::parse_state_t cur;
    dhcp_tlv_pkg::parse_state_t nxt;
    logic [31:0] placed;
    logic        place_ok;
    logic [7:0]  left_dec;

    always_comb
    begin
        cur = st_reg;
        // a new message starts from a clean parse with fresh header addresses
        if (first_byte)
        begin
            cur.phase       = dhcp_tlv_pkg::PH_CODE;
            cur.code        = '0;
            cur.left        = '0;
            cur.vidx        = '0;
            cur.pos         = '0;
            cur.type_val    = '0;
            cur.server_val  = '0;
            cur.req_val     = '0;
            cur.req_seen    = 1'b0;
            cur.your_addr   = your_addr;
            cur.client_addr = client_addr;
        end

        // address bytes land big-endian; bytes past the fourth drop out
        place_ok = (cur.vidx[7:2] == 6'd0);
        case (cur.vidx[1:0])
            2'd0:    placed = {opt_byte, 24'h0};
            2'd1:    placed = {8'h0, opt_byte, 16'h0};
            2'd2:    placed = {16'h0, opt_byte, 8'h0};
            default: placed = {24'h0, opt_byte};
        endcase
        left_dec = cur.left - 8'd1;

        nxt = cur;
        if (cur.phase != dhcp_tlv_pkg::PH_END && cur.pos < AREA_LIMIT)
        begin
            if (cur.pos != dhcp_tlv_pkg::POS_MAX)
                nxt.pos = cur.pos + dhcp_tlv_pkg::POS_W'(1);
            case (cur.phase)
                dhcp_tlv_pkg::PH_CODE:
                begin
                    if (opt_byte == dhcp_tlv_pkg::OPT_END)
                        nxt.phase = dhcp_tlv_pkg::PH_END;
                    else if (opt_byte != dhcp_tlv_pkg::OPT_PAD)
                    begin
                        nxt.code  = opt_byte;
                        nxt.phase = dhcp_tlv_pkg::PH_LEN;
                    end
                end
                dhcp_tlv_pkg::PH_LEN:
                begin
                    nxt.left = opt_byte;
                    nxt.vidx = '0;
                    if (cur.code == dhcp_tlv_pkg::OPT_SERVER_ID)
                        nxt.server_val = '0;
                    if (cur.code == dhcp_tlv_pkg::OPT_REQ_IP)
                    begin
                        nxt.req_val  = '0;
                        nxt.req_seen = 1'b1;
                    end
                    nxt.phase = (opt_byte == 8'd0) ? dhcp_tlv_pkg::PH_CODE
                                                   : dhcp_tlv_pkg::PH_VALUE;
                end
                dhcp_tlv_pkg::PH_VALUE:
                begin
                    if (cur.code == dhcp_tlv_pkg::OPT_MSG_TYPE && cur.vidx == 8'd0)
                        nxt.type_val = opt_byte;
                    else if (cur.code == dhcp_tlv_pkg::OPT_SERVER_ID && place_ok)
                        nxt.server_val = cur.server_val | placed;
                    else if (cur.code == dhcp_tlv_pkg::OPT_REQ_IP && place_ok)
                        nxt.req_val = cur.req_val | placed;
                    if (cur.vidx != dhcp_tlv_pkg::VIDX_MAX)
                        nxt.vidx = cur.vidx + 8'd1;
                    nxt.left = left_dec;
                    if (left_dec == 8'd0)
                        nxt.phase = dhcp_tlv_pkg::PH_CODE;
                end
                default: ;
            endcase
        end

        st_next = step ? nxt : st_reg;
    end

    always_comb
    begin
        summary.message_type = nxt.type_val;
        summary.server_id    = nxt.server_val;
        summary.requested_ip = nxt.req_val;
        summary.end_seen     = (nxt.phase == dhcp_tlv_pkg::PH_END);
        if (nxt.your_addr != 32'd0)
        begin
            summary.offered_ip     = nxt.your_addr;
            summary.offered_source = dhcp_tlv_pkg::SRC_YOUR;
        end
        else if (nxt.client_addr != 32'd0)
        begin
            summary.offered_ip     = nxt.client_addr;
            summary.offered_source = dhcp_tlv_pkg::SRC_CLIENT;
        end
        else if (nxt.req_seen)
        begin
            summary.offered_ip     = nxt.req_val;
            summary.offered_source = dhcp_tlv_pkg::SRC_REQ;
        end
        else
        begin
            summary.offered_ip     = 32'd0;
            summary.offered_source = dhcp_tlv_pkg::SRC_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase       <= dhcp_tlv_pkg::PH_CODE;
            st_reg.code        <= '0;
            st_reg.left        <= '0;
            st_reg.vidx        <= '0;
            st_reg.pos         <= '0;
            st_reg.type_val    <= '0;
            st_reg.server_val  <= '0;
            st_reg.req_val     <= '0;
            st_reg.req_seen    <= 1'b0;
            st_reg.your_addr   <= '0;
            st_reg.client_addr <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

[src/dhcp_tlv_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_tlv_checker
// Port-level checks on the TLV parser, bound to the top level.
// ----------------------------------------------------------------------------
module dhcp_tlv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] requested_ip,
    input logic [31:0] offered_ip,
    input logic [1:0]  offered_source
);

    // a pending result is held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // a fresh result must follow an accepted last-byte request through the input and result registers
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
        else $error("result without a last-byte request");

    a_no_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && offered_source == dhcp_tlv_pkg::SRC_NONE |-> offered_ip == 32'd0)
        else $error("offered address set with no source");

    a_req_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && offered_source == dhcp_tlv_pkg::SRC_REQ |-> offered_ip == requested_ip)
        else $error("offered address differs from requested address");

endmodule

bind dhcp_option_tlv_parser_top dhcp_tlv_checker u_dhcp_tlv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (opt.valid),
    .in_ready      (opt.ready),
    .in_last       (opt.last_byte),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .requested_ip  (res.requested_ip),
    .offered_ip    (res.offered_ip),
    .offered_source(res.offered_source)
);
